[rtl/core/assert_macros.svh]
// assertion macros, included by bitmap_block_allocator.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define BBA_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("invariant violated");
`define BBA_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication violated");
`else
`define BBA_ASSERT_ALWAYS(lbl, expr)
`define BBA_ASSERT_IMPLIES(lbl, ante, cons)
`endif

`endif

[rtl/core/bba_pkg.sv]
// types and constants of the bitmap block allocator
package bba_pkg;

  localparam int BLK_W   = 12;
  localparam int BLK_CAP = 4095;

  typedef enum logic [1:0] {
    MODE_ALLOC = 2'd0,
    MODE_PEEK  = 2'd1,
    MODE_COUNT = 2'd2,
    MODE_FREE  = 2'd3
  } bba_mode_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_BADFREE = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic clear;      // write zero at the sweep address, step it
    logic take;       // latch the request item
    logic start;      // load the map address for the request
    logic read;       // read the map byte
    logic next;       // step to the next byte of the scan
    logic mark_full;
    logic mark_bad;
    logic found;      // record the free block, prepare the set byte
    logic release_bit;
    logic write;      // write the modified byte, adjust the count
    logic emit;       // load the output register
  } bba_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic is_count;
    logic is_free;
    logic is_peek;
    logic range_bad;
    logic map_full;
    logic hit;
    logic last_byte;
    logic out_free;
  } bba_stat_t;

endpackage

[rtl/core/bba_ram.sv]
// generic single port ram with registered read
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

[rtl/core/bba_ctrl.sv]
// controller state machine of the bitmap block allocator
module bba_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  bba_pkg::bba_stat_t stat,
  output bba_pkg::bba_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_DECODE = 7'b0000100,
    S_READ   = 7'b0001000,
    S_EVAL   = 7'b0010000,
    S_WRITE  = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.take   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.is_count) begin
          state_next = S_DONE;
        end else if (stat.is_free) begin
          if (stat.range_bad) begin
            cmd.mark_bad = 1'b1;
            state_next   = S_DONE;
          end else begin
            cmd.start  = 1'b1;
            state_next = S_READ;
          end
        end else if (stat.map_full) begin
          cmd.mark_full = 1'b1;
          state_next    = S_DONE;
        end else begin
          cmd.start  = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (stat.is_free) begin
          if (stat.hit) begin
            cmd.release_bit = 1'b1;
            state_next      = S_WRITE;
          end else begin
            cmd.mark_bad = 1'b1;
            state_next   = S_DONE;
          end
        end else if (stat.hit) begin
          cmd.found  = 1'b1;
          state_next = stat.is_peek ? S_DONE : S_WRITE;
        end else if (stat.last_byte) begin
          cmd.mark_full = 1'b1;
          state_next    = S_DONE;
        end else begin
          cmd.next   = 1'b1;
          state_next = S_READ;
        end
      end
      S_WRITE: begin
        cmd.write  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

[rtl/core/bba_dp.sv]
// datapath of the bitmap block allocator: map memory, scan address, count, result
module bba_dp #(
  parameter int MAP_BYTES = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [15:0]        s_tdata,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [31:0]        m_tdata,
  input  bba_pkg::bba_cmd_t  cmd,
  output bba_pkg::bba_stat_t stat
);

  localparam int AW         = $clog2(MAP_BYTES);
  localparam int BW         = AW + 4;
  localparam int RAW_BLOCKS = MAP_BYTES * 8;
  localparam int NUM_BLOCKS = (RAW_BLOCKS > bba_pkg::BLK_CAP) ? bba_pkg::BLK_CAP : RAW_BLOCKS;
  localparam int LAST_SCAN  = (NUM_BLOCKS - 1) / 8;

  logic [1:0]              mode;
  logic [bba_pkg::BLK_W-1:0] req;
  logic [bba_pkg::BLK_W-1:0] req_pos;
  logic [AW-1:0]           addr;
  logic [7:0]              rdata;
  logic [7:0]              wbyte;
  logic [bba_pkg::BLK_W-1:0] used_count;
  logic [bba_pkg::BLK_W-1:0] blk_res;
  logic [1:0]              st_res;

  logic [15:0]             pos_ext;
  logic [2:0]              low_zero;
  logic [BW-1:0]           scan_blk;
  logic                    scan_hit;
  logic                    free_hit;
  logic [7:0]              ram_wdata;

  bba_ram #(
    .WIDTH (8),
    .DEPTH (MAP_BYTES)
  ) u_map (
    .clk   (clk),
    .we    (cmd.clear | cmd.write),
    .re    (cmd.read),
    .addr  (addr),
    .wdata (ram_wdata),
    .rdata (rdata)
  );

  assign ram_wdata = cmd.clear ? 8'h00 : wbyte;
  assign pos_ext   = {4'b0, req_pos};

  // lowest clear bit of the byte just read
  always_comb begin
    low_zero = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (!rdata[i]) low_zero = 3'(i);
    end
  end

  assign scan_blk = {1'b0, addr, low_zero} + BW'(1);
  assign scan_hit = (rdata != 8'hFF) && (scan_blk <= BW'(NUM_BLOCKS));
  assign free_hit = rdata[req_pos[2:0]];

  always_comb begin
    stat.clr_last  = (addr == AW'(MAP_BYTES - 1));
    stat.is_count  = (mode == bba_pkg::MODE_COUNT);
    stat.is_free   = (mode == bba_pkg::MODE_FREE);
    stat.is_peek   = (mode == bba_pkg::MODE_PEEK);
    stat.range_bad = (req == '0) || (req > bba_pkg::BLK_W'(NUM_BLOCKS));
    stat.map_full  = (used_count == bba_pkg::BLK_W'(NUM_BLOCKS));
    stat.hit       = (mode == bba_pkg::MODE_FREE) ? free_hit : scan_hit;
    stat.last_byte = (addr == AW'(LAST_SCAN));
    stat.out_free  = !m_tvalid || m_tready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr       <= '0;
      used_count <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cmd.clear || cmd.next) begin
        addr <= addr + AW'(1);
      end else if (cmd.start) begin
        addr <= (mode == bba_pkg::MODE_FREE) ? pos_ext[AW+2:3] : '0;
      end
      if (cmd.write) begin
        if (mode == bba_pkg::MODE_ALLOC) begin
          used_count <= used_count + bba_pkg::BLK_W'(1);
        end else begin
          used_count <= used_count - bba_pkg::BLK_W'(1);
        end
      end
      if (cmd.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      mode    <= s_tdata[1:0];
      req     <= s_tdata[13:2];
      req_pos <= s_tdata[13:2] - bba_pkg::BLK_W'(1);
      blk_res <= '0;
      st_res  <= bba_pkg::ST_OK;
    end
    if (cmd.mark_full) st_res <= bba_pkg::ST_FULL;
    if (cmd.mark_bad) st_res <= bba_pkg::ST_BADFREE;
    if (cmd.found) begin
      blk_res <= bba_pkg::BLK_W'(scan_blk);
      wbyte   <= rdata | (8'h01 << low_zero);
    end
    if (cmd.release_bit) begin
      wbyte <= rdata & ~(8'h01 << req_pos[2:0]);
    end
    if (cmd.emit) begin
      m_tdata <= {6'b0, st_res, used_count, blk_res};
    end
  end

endmodule

[rtl/core/bitmap_block_allocator.sv]
// bitmap block allocator: first-free search, free, and usage count over a block bitmap
//
// input channel s_*: one request item per handshake; tdata carries mode (0 allocate,
// 1 peek, 2 count, 3 free) and the block number to free, counted from 1.
// output channel m_*: exactly one result item per request, in request order; tdata
// carries the allocated or next free block number (0 if none), the used count after
// the request and a status (0 ok, 1 map full, 2 bad free).
// from acceptance to m_tvalid a count passes decode and done, a free decode, read,
// evaluate, write and done, a bad free decode and done when out of range and decode,
// read, evaluate and done when the block is already free.
// allocate and peek read the map one byte at a time through the single ram port, each
// byte in a read and an evaluate state, stopping at the first byte with a clear bit;
// a peek skips the write state. a full map is known from the count without a scan.
// s_tready rises in the same cycle as the result appears in the output register; a
// result may wait for the receiver while the next request is in work; if the receiver
// stalls longer the block holds the new result and stops taking requests.
// after reset the map ram is zeroed one byte a cycle, all MAP_BYTES bytes, with
// s_tready low; the used count starts at zero.
`include "assert_macros.svh"

module bitmap_block_allocator #(
  parameter int MAP_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // mode [1:0], block_to_free [13:2], zero [15:14]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // block_number [11:0], used_blocks [23:12], status [25:24]
);

  localparam int RAW_BLOCKS = MAP_BYTES * 8;
  localparam int NUM_BLOCKS = (RAW_BLOCKS > bba_pkg::BLK_CAP) ? bba_pkg::BLK_CAP : RAW_BLOCKS;

  bba_pkg::bba_cmd_t  cmd;
  bba_pkg::bba_stat_t stat;

  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bba_dp #(
    .MAP_BYTES (MAP_BYTES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .stat     (stat)
  );

  `BBA_ASSERT_IMPLIES(a_emit_slot_free, cmd.emit, stat.out_free)
  `BBA_ASSERT_IMPLIES(a_used_in_range, m_tvalid, m_tdata[23:12] <= 12'(NUM_BLOCKS))
  `BBA_ASSERT_IMPLIES(a_block_ok, m_tvalid && |m_tdata[11:0], m_tdata[25:24] == bba_pkg::ST_OK)

endmodule
